[src/cpmd_pkg.sv]
// Shared types and constants for the cascaded PID motor drive unit.
package cpmd_pkg;

    localparam int MAX_DRIVE      = 1000;
    localparam int MAX_SPEED      = 1000;
    localparam int INTEGRAL_LIMIT = 1000;

    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int DZ_W    = 15;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int INTEG_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int ISUM_W  = DIFF_W;
    localparam int PROD_W  = GAIN_W + DIFF_W;
    localparam int FRAC_W  = 8;
    localparam int ACC_W   = PROD_W - FRAC_W + 1;
    localparam int DRIVE_W = 11;
    localparam int CMP_W   = 10;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_SPEED_KP = 3'd1,
        REG_SPEED_KI = 3'd2,
        REG_SPEED_KD = 3'd3,
        REG_ANGLE_KP = 3'd4,
        REG_ANGLE_KI = 3'd5,
        REG_ANGLE_KD = 3'd6,
        REG_DEAD     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] speed_kp;
        logic signed [GAIN_W-1:0] speed_ki;
        logic signed [GAIN_W-1:0] speed_kd;
        logic signed [GAIN_W-1:0] angle_kp;
        logic signed [GAIN_W-1:0] angle_ki;
        logic signed [GAIN_W-1:0] angle_kd;
        logic        [DZ_W-1:0]   dead_zone;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_ACC,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   angle;
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_FIN
    } state_t;

endpackage

[src/cpmd_cfg.sv]
// Configuration register file: mode, loop gains and deadband.
module cpmd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpmd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cpmd_pkg::CFG_W-1:0]      cfg_data,
    output cpmd_pkg::cfg_t                  cfg
);
    import cpmd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 1'b0;
            cfg_reg.speed_kp  <= GAIN_W'(128);
            cfg_reg.speed_ki  <= '0;
            cfg_reg.speed_kd  <= '0;
            cfg_reg.angle_kp  <= GAIN_W'(128);
            cfg_reg.angle_ki  <= '0;
            cfg_reg.angle_kd  <= '0;
            cfg_reg.dead_zone <= DZ_W'(200);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:     cfg_reg.mode      <= cfg_data[0];
                REG_SPEED_KP: cfg_reg.speed_kp  <= cfg_data[GAIN_W-1:0];
                REG_SPEED_KI: cfg_reg.speed_ki  <= cfg_data[GAIN_W-1:0];
                REG_SPEED_KD: cfg_reg.speed_kd  <= cfg_data[GAIN_W-1:0];
                REG_ANGLE_KP: cfg_reg.angle_kp  <= cfg_data[GAIN_W-1:0];
                REG_ANGLE_KI: cfg_reg.angle_ki  <= cfg_data[GAIN_W-1:0];
                REG_ANGLE_KD: cfg_reg.angle_kd  <= cfg_data[GAIN_W-1:0];
                REG_DEAD:     cfg_reg.dead_zone <= cfg_data[DZ_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/cpmd_dp.sv]
// Datapath: error, integral, shared multiplier, accumulator and output words.
module cpmd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpmd_pkg::cfg_t                      cfg,
    input  cpmd_pkg::dp_cmd_t                   cmd,
    output cpmd_pkg::dp_status_t                status,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  setpoint,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  measured_speed,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  measured_angle,
    output logic signed [cpmd_pkg::DRIVE_W-1:0] drive,
    output logic        [cpmd_pkg::CMP_W-1:0]   compare_fwd,
    output logic        [cpmd_pkg::CMP_W-1:0]   compare_rev,
    output logic signed [cpmd_pkg::DATA_W-1:0]  speed_target_used
);
    import cpmd_pkg::*;

    localparam logic signed [ISUM_W-1:0] ILIM_POS = ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ISUM_W-1:0] ILIM_NEG = -ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ACC_W-1:0]  DRV_POS  = ACC_W'(MAX_DRIVE);
    localparam logic signed [ACC_W-1:0]  SPD_POS  = ACC_W'(MAX_SPEED);

    logic signed [DATA_W-1:0]  sp_reg, ms_reg, ma_reg, starget_reg;
    logic signed [INTEG_W-1:0] speed_integ_reg, angle_integ_reg;
    logic signed [ERR_W-1:0]   speed_prev_reg, angle_prev_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      dead_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic        [CMP_W-1:0]   fwd_reg, rev_reg;
    logic signed [DATA_W-1:0]  stu_reg;

    logic signed [DATA_W-1:0]  tgt, cur;
    logic signed [INTEG_W-1:0] integ_sel, integ_new;
    logic signed [ERR_W-1:0]   prev_sel, err_c, dz_pos, dz_neg;
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [ISUM_W-1:0]  isum;
    logic                      dead_c;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [ACC_W-1:0]   acc_add, lim_pos, lim_neg, clamp_c;
    logic signed [DATA_W-1:0]  val_c;
    logic signed [DATA_W:0]    fwd_c, rev_c;

    always_comb
    begin
        tgt       = cmd.angle ? sp_reg : starget_reg;
        cur       = cmd.angle ? ma_reg : ms_reg;
        integ_sel = cmd.angle ? angle_integ_reg : speed_integ_reg;
        prev_sel  = cmd.angle ? angle_prev_reg : speed_prev_reg;

        err_c  = {tgt[DATA_W-1], tgt} - {cur[DATA_W-1], cur};
        diff_c = {err_c[ERR_W-1], err_c} - {prev_sel[ERR_W-1], prev_sel};
        isum   = {{(ISUM_W-INTEG_W){integ_sel[INTEG_W-1]}}, integ_sel}
               + {{(ISUM_W-ERR_W){err_c[ERR_W-1]}}, err_c};
        if (isum > ILIM_POS)
            integ_new = ILIM_POS[INTEG_W-1:0];
        else if (isum < ILIM_NEG)
            integ_new = ILIM_NEG[INTEG_W-1:0];
        else
            integ_new = isum[INTEG_W-1:0];

        dz_pos = {{(ERR_W-DZ_W){1'b0}}, cfg.dead_zone};
        dz_neg = -dz_pos;
        dead_c = (err_c <= dz_pos) && (err_c >= dz_neg);

        case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = cmd.angle ? cfg.angle_kp : cfg.speed_kp;
                mul_b = {err_reg[ERR_W-1], err_reg};
            end
            OP_MUL_I:
            begin
                mul_a = cmd.angle ? cfg.angle_ki : cfg.speed_ki;
                mul_b = {{(DIFF_W-INTEG_W){integ_sel[INTEG_W-1]}}, integ_sel};
            end
            OP_MUL_D:
            begin
                mul_a = cmd.angle ? cfg.angle_kd : cfg.speed_kd;
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_c = mul_a * mul_b;

        // floor shift of the product by the Q8.8 fraction
        acc_add = acc_reg + {prod_reg[PROD_W-1], prod_reg[PROD_W-1:FRAC_W]};

        lim_pos = cmd.angle ? SPD_POS : DRV_POS;
        lim_neg = -lim_pos;
        if (dead_reg)
            clamp_c = '0;
        else if (acc_reg > lim_pos)
            clamp_c = lim_pos;
        else if (acc_reg < lim_neg)
            clamp_c = lim_neg;
        else
            clamp_c = acc_reg;
        val_c = clamp_c[DATA_W-1:0];

        fwd_c = (DATA_W+1)'(MAX_DRIVE) - {val_c[DATA_W-1], val_c};
        rev_c = (DATA_W+1)'(MAX_DRIVE) + {val_c[DATA_W-1], val_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_integ_reg <= '0;
            angle_integ_reg <= '0;
            speed_prev_reg  <= '0;
            angle_prev_reg  <= '0;
        end
        else if (cmd.op == OP_ERR)
        begin
            if (cmd.angle)
            begin
                angle_integ_reg <= dead_c ? '0 : integ_new;
                if (!dead_c)
                    angle_prev_reg <= err_c;
            end
            else
            begin
                speed_integ_reg <= dead_c ? '0 : integ_new;
                if (!dead_c)
                    speed_prev_reg <= err_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sp_reg      <= setpoint;
            ms_reg      <= measured_speed;
            ma_reg      <= measured_angle;
            starget_reg <= setpoint;
        end
        case (cmd.op)
            OP_ERR:
            begin
                err_reg  <= err_c;
                diff_reg <= diff_c;
                dead_reg <= dead_c;
                acc_reg  <= '0;
            end
            OP_MUL_P:
                prod_reg <= prod_c;
            OP_MUL_I, OP_MUL_D:
            begin
                prod_reg <= prod_c;
                acc_reg  <= acc_add;
            end
            OP_ACC:
                acc_reg <= acc_add;
            OP_FIN:
            begin
                if (cmd.angle)
                    starget_reg <= val_c;
            end
            default:
                ;
        endcase
        if (cmd.out_load)
        begin
            drive_reg <= val_c[DRIVE_W-1:0];
            fwd_reg   <= val_c[DATA_W-1] ? '0 : fwd_c[CMP_W-1:0];
            rev_reg   <= val_c[DATA_W-1] ? rev_c[CMP_W-1:0] : '0;
            stu_reg   <= starget_reg;
        end
    end

    assign status.dead       = dead_c;
    assign drive             = drive_reg;
    assign compare_fwd       = fwd_reg;
    assign compare_rev       = rev_reg;
    assign speed_target_used = stu_reg;

endmodule

[src/cpmd_ctrl.sv]
// Controller: sequences the angle and speed loop steps and the word handshakes.
module cpmd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mode,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  cpmd_pkg::dp_status_t   status,
    output cpmd_pkg::dp_cmd_t      cmd
);
    import cpmd_pkg::*;

    state_t state_reg, state_next;
    logic   angle_reg, angle_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            angle_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            angle_reg     <= angle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        angle_next   = angle_reg;
        cmd.load     = 1'b0;
        cmd.angle    = angle_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    angle_next = mode;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = status.dead ? ST_FIN : ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.op     = OP_MUL_I;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (angle_reg)
                begin
                    cmd.op     = OP_FIN;
                    angle_next = 1'b0;
                    state_next = ST_ERR;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    cmd.op       = OP_FIN;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_ERR && angle_reg == $past(mode)))
        else $error("accepted word did not start the loop sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_out_only_speed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!angle_reg && state_reg == ST_FIN))
        else $error("result loaded outside the speed loop finish");

endmodule

[src/cascaded_pid_motor_drive_unit.sv]
// Cascaded PID motor drive: top level joining config, controller and datapath.
// One control word is taken while the unit is idle; the loops then run on one
// shared 16x18 signed multiplier, three products per loop plus an error step,
// a closing accumulate step and a finish step; angle mode runs the angle loop
// before the speed loop. A loop whose error falls inside the deadband skips its
// multiplies, going from its error step to its finish step. The result sits in
// an output register, so a stalled result only holds the unit once the next
// result is ready to be written. Register writes take effect at once, so write
// configuration only while no word is in flight.
module cascaded_pid_motor_drive_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpmd_pkg::IDX_W-1:0]          cfg_index,
    input  logic [cpmd_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  setpoint,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  measured_speed,
    input  logic signed [cpmd_pkg::DATA_W-1:0]  measured_angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cpmd_pkg::DRIVE_W-1:0] drive,
    output logic        [cpmd_pkg::CMP_W-1:0]   compare_fwd,
    output logic        [cpmd_pkg::CMP_W-1:0]   compare_rev,
    output logic signed [cpmd_pkg::DATA_W-1:0]  speed_target_used
);
    import cpmd_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    cpmd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (cfg.mode),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cpmd_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .setpoint          (setpoint),
        .measured_speed    (measured_speed),
        .measured_angle    (measured_angle),
        .drive             (drive),
        .compare_fwd       (compare_fwd),
        .compare_rev       (compare_rev),
        .speed_target_used (speed_target_used)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for the cascaded PID motor drive unit.
module tb;
    import cpmd_pkg::*;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic        [CMP_W-1:0]   fwd;
        logic        [CMP_W-1:0]   rev;
        logic signed [DATA_W-1:0]  target;
    } drive_word_t;

    typedef struct packed {
        logic                      typed;
        logic signed [DATA_W-1:0]  sp;
        logic signed [DATA_W-1:0]  ms;
        logic signed [DATA_W-1:0]  ma;
        drive_word_t               want;
    } tick_row_t;

    localparam int DIR_N      = 20;
    localparam int ANGLE_ROW  = 11;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 128;
    localparam int SETTLE     = 30;

    // rows before ANGLE_ROW run with reset settings, the rest in angle mode
    localparam tick_row_t TICK_ROWS [DIR_N] = '{
        '{1'b1, 16'sd1000, 16'sd0, 16'sd0, '{11'sd500, 10'd500, 10'd0, 16'sd1000}},
        '{1'b1, 16'sd0, 16'sd0, 16'sd0, '{11'sd0, 10'd1000, 10'd0, 16'sd0}},
        '{1'b1, 16'sd200, 16'sd0, 16'sd0, '{11'sd0, 10'd1000, 10'd0, 16'sd200}},
        '{1'b1, -16'sd200, 16'sd0, 16'sd0, '{11'sd0, 10'd1000, 10'd0, -16'sd200}},
        '{1'b1, 16'sd201, 16'sd0, 16'sd0, '{11'sd100, 10'd900, 10'd0, 16'sd201}},
        '{1'b1, -16'sd201, 16'sd0, 16'sd0, '{-11'sd101, 10'd0, 10'd899, -16'sd201}},
        '{1'b1, 16'sh7FFF, 16'sh8000, 16'sd0, '{11'sd1000, 10'd0, 10'd0, 16'sh7FFF}},
        '{1'b1, 16'sh8000, 16'sh7FFF, 16'sd0, '{-11'sd1000, 10'd0, 10'd0, 16'sh8000}},
        '{1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF, '{11'sd0, 10'd1000, 10'd0, 16'sh8000}},
        '{1'b1, 16'sd0, 16'sd2000, 16'sd0, '{-11'sd1000, 10'd0, 10'd0, 16'sd0}},
        '{1'b0, 16'sh5555, 16'sh2AAA, -16'sd1, '0},
        '{1'b1, 16'sd0, 16'sd0, 16'sd0, '{11'sd0, 10'd1000, 10'd0, 16'sd0}},
        '{1'b0, 16'sd1000, 16'sd0, 16'sd0, '0},
        '{1'b0, 16'sd1000, 16'sd200, 16'sd300, '0},
        '{1'b0, 16'sd1000, 16'sd500, 16'sd600, '0},
        '{1'b0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, '0},
        '{1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, '0},
        '{1'b0, 16'sd40, 16'sd0, 16'sd0, '0},
        '{1'b0, 16'sd500, -16'sd900, 16'sd480, '0},
        '{1'b0, -16'sd3000, 16'sd0, 16'sd0, '0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [DATA_W-1:0]  setpoint;
    logic signed [DATA_W-1:0]  measured_speed;
    logic signed [DATA_W-1:0]  measured_angle;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] drive;
    logic        [CMP_W-1:0]   compare_fwd;
    logic        [CMP_W-1:0]   compare_rev;
    logic signed [DATA_W-1:0]  speed_target_used;

    cascaded_pid_motor_drive_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .setpoint          (setpoint),
        .measured_speed    (measured_speed),
        .measured_angle    (measured_angle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .drive             (drive),
        .compare_fwd       (compare_fwd),
        .compare_rev       (compare_rev),
        .speed_target_used (speed_target_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cfg_t        loop_cfg;
    int          spd_integ;
    int          spd_prev;
    int          ang_integ;
    int          ang_prev;
    drive_word_t pending_drive [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          stall_span = 0;
    int          stall_kind = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    function automatic int pid_step(input int target, input int current, input int kp,
                                    input int ki, input int kd, input int lim,
                                    inout int integ, inout int prev);
        int     err;
        int     dz;
        longint acc;
        err = target - current;
        dz  = int'(loop_cfg.dead_zone);
        if (err <= dz && err >= -dz)
        begin
            integ = 0;
            return 0;
        end
        integ = integ + err;
        if (integ > INTEGRAL_LIMIT)
            integ = INTEGRAL_LIMIT;
        else if (integ < -INTEGRAL_LIMIT)
            integ = -INTEGRAL_LIMIT;
        acc = ((longint'(kp) * err) >>> 8) + ((longint'(ki) * integ) >>> 8)
            + ((longint'(kd) * (err - prev)) >>> 8);
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        prev = err;
        return int'(acc);
    endfunction

    function automatic drive_word_t predict_drive(input int sp, input int ms, input int ma);
        drive_word_t w;
        int          tgt;
        int          d;
        tgt = sp;
        if (loop_cfg.mode)
            tgt = pid_step(sp, ma, loop_cfg.angle_kp, loop_cfg.angle_ki, loop_cfg.angle_kd,
                           MAX_SPEED, ang_integ, ang_prev);
        d = pid_step(tgt, ms, loop_cfg.speed_kp, loop_cfg.speed_ki, loop_cfg.speed_kd,
                     MAX_DRIVE, spd_integ, spd_prev);
        w.drive  = DRIVE_W'(d);
        w.fwd    = (d >= 0) ? CMP_W'(MAX_DRIVE - d) : '0;
        w.rev    = (d < 0) ? CMP_W'(MAX_DRIVE + d) : '0;
        w.target = DATA_W'(tgt);
        return w;
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        if ($urandom_range(0, 3) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'(int'($urandom_range(0, 1200)) - 600);
    endfunction

    function automatic cfg_t pick_cfg(input int phase);
        cfg_t c;
        case (phase)
            0, 2:
            begin
                c.mode     = (phase == 2);
                c.speed_kp = 16'sh7FFF;
                c.speed_ki = 16'sh7FFF;
                c.speed_kd = 16'sh7FFF;
                c.angle_kp = 16'sh7FFF;
                c.angle_ki = 16'sh7FFF;
                c.angle_kd = 16'sh7FFF;
                c.dead_zone = '0;
            end
            1, 3:
            begin
                c.mode     = (phase == 1);
                c.speed_kp = 16'sh8000;
                c.speed_ki = 16'sh8000;
                c.speed_kd = 16'sh8000;
                c.angle_kp = 16'sh8000;
                c.angle_ki = 16'sh8000;
                c.angle_kd = 16'sh8000;
                c.dead_zone = '1;
            end
            default:
            begin
                c.mode     = phase[0];
                c.speed_kp = rand_gain();
                c.speed_ki = rand_gain();
                c.speed_kd = rand_gain();
                c.angle_kp = rand_gain();
                c.angle_ki = rand_gain();
                c.angle_kd = rand_gain();
                if ($urandom_range(0, 3) == 0)
                    c.dead_zone = DZ_W'($urandom);
                else
                    c.dead_zone = DZ_W'($urandom_range(0, 300));
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // unused upper bits of the narrow registers carry junk
    task automatic set_regs(input cfg_t c);
        write_reg(REG_MODE, {15'($urandom), c.mode});
        write_reg(REG_SPEED_KP, c.speed_kp);
        write_reg(REG_SPEED_KI, c.speed_ki);
        write_reg(REG_SPEED_KD, c.speed_kd);
        write_reg(REG_ANGLE_KP, c.angle_kp);
        write_reg(REG_ANGLE_KI, c.angle_ki);
        write_reg(REG_ANGLE_KD, c.angle_kd);
        write_reg(REG_DEAD, {1'($urandom), c.dead_zone});
        cfg_we   <= 1'b0;
        loop_cfg = c;
    endtask

    task automatic send_word(input int sp, input int ms, input int ma);
        in_valid       <= 1'b1;
        setpoint       <= DATA_W'(sp);
        measured_speed <= DATA_W'(ms);
        measured_angle <= DATA_W'(ma);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            in_valid       <= 1'b0;
            setpoint       <= DATA_W'($urandom);
            measured_speed <= DATA_W'($urandom);
            measured_angle <= DATA_W'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic gen_tick(output int sp, output int ms, output int ma);
        int kind;
        int d;
        kind = $urandom_range(0, 9);
        sp = int'($signed(16'($urandom)));
        ms = int'($signed(16'($urandom)));
        ma = int'($signed(16'($urandom)));
        if (kind >= 3)
        begin
            sp = int'($urandom_range(0, 40000)) - 20000;
            if (kind == 9)
                d = (int'(loop_cfg.dead_zone) + int'($urandom_range(0, 1)))
                    * ($urandom_range(0, 1) ? 1 : -1);
            else
                d = int'($urandom_range(0, 3000)) - 1500;
            if (loop_cfg.mode)
            begin
                ma = sat16(sp - d);
                ms = int'($urandom_range(0, 2400)) - 1200;
            end
            else
                ms = sat16(sp - d);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_kind <= $urandom_range(0, 2);
            stall_span <= $urandom_range(10, 150);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_words
        drive_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive.size() == 0)
                report_mismatch("word with none expected, drive", int'(drive), 0);
            else
            begin
                want = pending_drive.pop_front();
                if (drive !== want.drive)
                    report_mismatch("drive", int'(drive), int'(want.drive));
                if (compare_fwd !== want.fwd)
                    report_mismatch("compare_fwd", int'(compare_fwd), int'(want.fwd));
                if (compare_rev !== want.rev)
                    report_mismatch("compare_rev", int'(compare_rev), int'(want.rev));
                if (speed_target_used !== want.target)
                    report_mismatch("speed_target_used", int'(speed_target_used),
                                    int'(want.target));
            end
        end
    end

    initial
    begin
        cfg_t        c;
        drive_word_t want;
        int          sp;
        int          ms;
        int          ma;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        setpoint       = '0;
        measured_speed = '0;
        measured_angle = '0;
        loop_cfg.mode      = 1'b0;
        loop_cfg.speed_kp  = 16'sd128;
        loop_cfg.speed_ki  = 16'sd0;
        loop_cfg.speed_kd  = 16'sd0;
        loop_cfg.angle_kp  = 16'sd128;
        loop_cfg.angle_ki  = 16'sd0;
        loop_cfg.angle_kd  = 16'sd0;
        loop_cfg.dead_zone = 15'd200;
        spd_integ = 0;
        spd_prev  = 0;
        ang_integ = 0;
        ang_prev  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (i == ANGLE_ROW)
            begin
                wait_idle();
                c.mode      = 1'b1;
                c.speed_kp  = 16'sd256;
                c.speed_ki  = 16'sd32;
                c.speed_kd  = -16'sd128;
                c.angle_kp  = 16'sd384;
                c.angle_ki  = 16'sd16;
                c.angle_kd  = 16'sd64;
                c.dead_zone = 15'd50;
                set_regs(c);
            end
            send_word(TICK_ROWS[i].sp, TICK_ROWS[i].ms, TICK_ROWS[i].ma);
            want = predict_drive(TICK_ROWS[i].sp, TICK_ROWS[i].ms, TICK_ROWS[i].ma);
            if (TICK_ROWS[i].typed)
                want = TICK_ROWS[i].want;
            pending_drive.push_back(want);
            pace();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_regs(pick_cfg(p));
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                gen_tick(sp, ms, ma);
                send_word(sp, ms, ma);
                pending_drive.push_back(predict_drive(sp, ms, ma));
                pace();
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
